// File: src/mtom_pkg.sv
// ----------------------------------------------------------------------------
// Motor thermal overload monitor package
// Shared widths, constants, sequencer states and the reciprocal on-time
// lookup for the two-motor overload protection block.
// ----------------------------------------------------------------------------
package mtom_pkg;

    localparam int ADC_BITS_DEF  = 10;
    localparam int TIME_BITS_DEF = 24;

    localparam int DT_W       = 20;
    localparam int CFG_W      = 24;
    localparam int CHARGE_W   = 28;
    localparam int FRAC_W     = 32;
    localparam int AVG_W      = 5;
    localparam int RECIP_W    = 17;
    localparam int IDX_W      = 5;
    localparam int Q_SHIFT    = 16;
    localparam int AMP_SHIFT  = 11;
    localparam int AMP_MUL_W  = 6;

    localparam logic [CFG_W-1:0]    CHECK_RESET = CFG_W'(100000);
    localparam logic [FRAC_W-1:0]   ONE_Q16     = FRAC_W'(32'h0001_0000);
    localparam logic [IDX_W-1:0]    IDX_TOP     = IDX_W'(16);
    localparam logic [AVG_W-1:0]    AVG_TOP     = {AVG_W{1'b1}};
    localparam logic [CHARGE_W-1:0] CHARGE_MAX  = {CHARGE_W{1'b1}};
    localparam logic [FRAC_W-1:0]   FRAC_MAX    = {FRAC_W{1'b1}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_CHK,
        ST_DIV,
        ST_MUL_L,
        ST_MUL_R,
        ST_ADD_R,
        ST_FIN
    } t_state;

    // Reciprocal of the permitted on-time at a given average current, unsigned Q1.16 per second.
    function automatic logic [RECIP_W-1:0] f_recip_ton(input logic [IDX_W-1:0] idx);
        logic [RECIP_W-1:0] v;
        unique case (idx)
            5'd3:    v = 17'd2576;
            5'd4:    v = 17'd5283;
            5'd5:    v = 17'd8727;
            5'd6:    v = 17'd12927;
            5'd7:    v = 17'd17885;
            5'd8:    v = 17'd23604;
            5'd9:    v = 17'd30084;
            5'd10:   v = 17'd37326;
            5'd11:   v = 17'd45328;
            5'd12:   v = 17'd54094;
            5'd13:   v = 17'd63621;
            5'd14:   v = 17'd73909;
            5'd15:   v = 17'd84960;
            5'd16:   v = 17'd96777;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: src/motor_thermal_overload_monitor_unit.sv
// ----------------------------------------------------------------------------
// Motor thermal overload monitor
// Accumulates current times time for two motors, averages it over each
// evaluation interval and integrates an i2t overload fraction per side.
// ----------------------------------------------------------------------------
//  Channel    | Direction | Handshake                   | Contents
//  s_axis     | in        | tvalid / tready             | elapsed_us, adc_left, adc_right
//  m_axis     | out       | tvalid / tready             | averages and trip flags, checked
//  cfg        | in        | wr_en, no back-pressure     | check_interval_us
//
// An item without an evaluation is paced by the bit-serial charge multiply
// from acceptance to the earliest next acceptance. An item that closes an
// interval also runs the 28-step restoring division, one divider per side,
// stepping together. The result register frees the input side: a new item is
// taken while the previous result waits, and an item holds in its last step
// only while that register is still full. Reset is synchronous and clears the
// control and accumulated state; the datapath registers are not reset.
// ----------------------------------------------------------------------------
module motor_thermal_overload_monitor_unit
    import mtom_pkg::*;
#(
    parameter int ADC_BITS  = ADC_BITS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF,
    localparam int IN_W       = DT_W + 2 * ADC_BITS,
    localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // elapsed_us, adc_left, adc_right, zero padding
    input  logic [IN_TDATA_W-1:0] i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // avg_amps_left, avg_amps_right, trip_left, trip_right, panic, zero padding
    output logic [15:0]           o_m_axis_tdata,
    // checked
    output logic                  o_m_axis_tuser,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_W-1:0]      i_cfg_wr_data
);

    localparam int AMP_W   = ADC_BITS + AMP_MUL_W - AMP_SHIFT;
    localparam int MC_W    = DT_W + AMP_W;
    localparam int ACC_W   = CHARGE_W + 1;
    localparam int TS_W    = ((TIME_BITS > DT_W) ? TIME_BITS : DT_W) + 1;
    localparam int CMP_W   = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;
    localparam int PROD_W  = TIME_BITS + RECIP_W;
    localparam int INC_W   = PROD_W - Q_SHIFT;
    localparam int FS_W    = ((INC_W > FRAC_W) ? INC_W : FRAC_W) + 1;
    localparam int CNT_W   = $clog2(CHARGE_W);
    localparam int OUT_W   = 2 * AVG_W + 3;

    t_state r_state, n_state;

    logic [CFG_W-1:0]     r_interval;
    logic [TIME_BITS-1:0] r_time;
    logic [CHARGE_W-1:0]  r_charge_l, r_charge_r;
    logic [FRAC_W-1:0]    r_frac_l, r_frac_r;
    logic [AVG_W-1:0]     r_avg_l, r_avg_r;
    logic                 r_checked;

    logic [ACC_W-1:0]     r_acc_l, r_acc_r;
    logic [AMP_W-1:0]     r_amp_l, r_amp_r;
    logic [MC_W-1:0]      r_mcand;
    logic [CNT_W-1:0]     r_cnt;
    logic [CHARGE_W-1:0]  r_quo_l, r_quo_r;
    logic [TIME_BITS-1:0] r_rem_l, r_rem_r;
    logic [PROD_W-1:0]    r_prod;

    logic                 r_out_valid;
    logic [OUT_W-1:0]     r_out_data;
    logic                 r_out_checked;

    logic                 w_s_ready;
    logic                 w_out_load;

    logic [DT_W-1:0]        w_dt;
    logic [ADC_BITS-1:0]    w_adc_l, w_adc_r;
    logic [AMP_W-1:0]       w_amps_l, w_amps_r;
    logic [ADC_BITS+AMP_MUL_W-1:0] w_scl_l, w_scl_r;
    logic [TS_W-1:0]        w_time_sum;
    logic [TIME_BITS-1:0]   w_time_sat;
    logic [CHARGE_W-1:0]    w_chg_sat_l, w_chg_sat_r;
    logic                   w_check;
    logic                   w_acc_last, w_div_last;
    logic [TIME_BITS:0]     w_rsh_l, w_rsh_r;
    logic                   w_ge_l, w_ge_r;
    logic [IDX_W-1:0]       w_idx_l, w_idx_r, w_idx_sel;
    logic [AVG_W-1:0]       w_avg_l, w_avg_r;
    logic [RECIP_W-1:0]     w_recip;
    logic [FS_W-1:0]        w_fsum_l, w_fsum_r;
    logic [FRAC_W-1:0]      w_frac_new_l, w_frac_new_r;
    logic                   w_trip_l, w_trip_r;

    // Input unpacking and scaling to whole amps (x33 / 2048).
    assign w_dt    = i_s_axis_tdata[DT_W-1:0];
    assign w_adc_l = i_s_axis_tdata[DT_W +: ADC_BITS];
    assign w_adc_r = i_s_axis_tdata[DT_W + ADC_BITS +: ADC_BITS];
    assign w_scl_l = ((ADC_BITS+AMP_MUL_W)'(w_adc_l) << 5) + (ADC_BITS+AMP_MUL_W)'(w_adc_l);
    assign w_scl_r = ((ADC_BITS+AMP_MUL_W)'(w_adc_r) << 5) + (ADC_BITS+AMP_MUL_W)'(w_adc_r);
    assign w_amps_l = w_scl_l[ADC_BITS+AMP_MUL_W-1:AMP_SHIFT];
    assign w_amps_r = w_scl_r[ADC_BITS+AMP_MUL_W-1:AMP_SHIFT];

    assign w_time_sum = TS_W'(r_time) + TS_W'(w_dt);
    assign w_time_sat = (w_time_sum > TS_W'({TIME_BITS{1'b1}})) ? {TIME_BITS{1'b1}}
                                                                 : w_time_sum[TIME_BITS-1:0];

    assign w_chg_sat_l = r_acc_l[CHARGE_W] ? CHARGE_MAX : r_acc_l[CHARGE_W-1:0];
    assign w_chg_sat_r = r_acc_r[CHARGE_W] ? CHARGE_MAX : r_acc_r[CHARGE_W-1:0];
    assign w_check     = CMP_W'(r_time) > CMP_W'(r_interval);

    assign w_acc_last = (r_cnt == CNT_W'(AMP_W - 1));
    assign w_div_last = (r_cnt == CNT_W'(CHARGE_W - 1));

    // One restoring division step per cycle for each side.
    assign w_rsh_l = {r_rem_l, r_quo_l[CHARGE_W-1]};
    assign w_rsh_r = {r_rem_r, r_quo_r[CHARGE_W-1]};
    assign w_ge_l  = w_rsh_l >= {1'b0, r_time};
    assign w_ge_r  = w_rsh_r >= {1'b0, r_time};

    assign w_idx_l = (r_quo_l > CHARGE_W'(IDX_TOP)) ? IDX_TOP : r_quo_l[IDX_W-1:0];
    assign w_idx_r = (r_quo_r > CHARGE_W'(IDX_TOP)) ? IDX_TOP : r_quo_r[IDX_W-1:0];
    assign w_avg_l = (r_quo_l > CHARGE_W'(AVG_TOP)) ? AVG_TOP : r_quo_l[AVG_W-1:0];
    assign w_avg_r = (r_quo_r > CHARGE_W'(AVG_TOP)) ? AVG_TOP : r_quo_r[AVG_W-1:0];
    assign w_idx_sel = (r_state == ST_MUL_L) ? w_idx_l : w_idx_r;
    assign w_recip   = f_recip_ton(w_idx_sel);

    assign w_fsum_l = FS_W'(r_frac_l) + FS_W'(r_prod[PROD_W-1:Q_SHIFT]);
    assign w_fsum_r = FS_W'(r_frac_r) + FS_W'(r_prod[PROD_W-1:Q_SHIFT]);
    assign w_frac_new_l = (w_fsum_l > FS_W'(FRAC_MAX)) ? FRAC_MAX : w_fsum_l[FRAC_W-1:0];
    assign w_frac_new_r = (w_fsum_r > FS_W'(FRAC_MAX)) ? FRAC_MAX : w_fsum_r[FRAC_W-1:0];

    assign w_trip_l = r_frac_l > ONE_Q16;
    assign w_trip_r = r_frac_r > ONE_Q16;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_s_axis_tvalid) n_state = ST_ACC;
            ST_ACC:   if (w_acc_last) n_state = ST_CHK;
            ST_CHK:   n_state = w_check ? ST_DIV : ST_FIN;
            ST_DIV:   if (w_div_last) n_state = ST_MUL_L;
            ST_MUL_L: n_state = ST_MUL_R;
            ST_MUL_R: n_state = ST_ADD_R;
            ST_ADD_R: n_state = ST_FIN;
            ST_FIN:   if (!r_out_valid || i_m_axis_tready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_s_ready  = (r_state == ST_IDLE);
        w_out_load = (r_state == ST_FIN) && (!r_out_valid || i_m_axis_tready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_interval  <= CHECK_RESET;
            r_time      <= '0;
            r_charge_l  <= '0;
            r_charge_r  <= '0;
            r_frac_l    <= '0;
            r_frac_r    <= '0;
            r_avg_l     <= '0;
            r_avg_r     <= '0;
            r_checked   <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_interval <= i_cfg_wr_data;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_cnt <= '0;
                    if (i_s_axis_tvalid) begin
                        r_time <= w_time_sat;
                    end
                end
                ST_ACC: begin
                    r_cnt <= w_acc_last ? '0 : r_cnt + CNT_W'(1);
                end
                ST_CHK: begin
                    r_checked  <= w_check;
                    r_charge_l <= w_check ? '0 : w_chg_sat_l;
                    r_charge_r <= w_check ? '0 : w_chg_sat_r;
                    r_cnt      <= '0;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
                ST_MUL_L: begin
                    r_avg_l <= w_avg_l;
                end
                ST_MUL_R: begin
                    r_avg_r  <= w_avg_r;
                    r_frac_l <= w_frac_new_l;
                end
                ST_ADD_R: begin
                    r_frac_r <= w_frac_new_r;
                    r_time   <= '0;
                end
                ST_FIN: begin
                    r_cnt <= '0;
                end
                default: begin
                    r_cnt <= '0;
                end
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_acc_l <= {1'b0, r_charge_l};
                r_acc_r <= {1'b0, r_charge_r};
                r_amp_l <= w_amps_l;
                r_amp_r <= w_amps_r;
                r_mcand <= MC_W'(w_dt);
            end
            ST_ACC: begin
                if (r_amp_l[0]) begin
                    r_acc_l <= r_acc_l + ACC_W'(r_mcand);
                end
                if (r_amp_r[0]) begin
                    r_acc_r <= r_acc_r + ACC_W'(r_mcand);
                end
                r_amp_l <= r_amp_l >> 1;
                r_amp_r <= r_amp_r >> 1;
                r_mcand <= r_mcand << 1;
            end
            ST_CHK: begin
                r_quo_l <= w_chg_sat_l;
                r_quo_r <= w_chg_sat_r;
                r_rem_l <= '0;
                r_rem_r <= '0;
            end
            ST_DIV: begin
                r_rem_l <= w_ge_l ? TIME_BITS'(w_rsh_l - {1'b0, r_time}) : w_rsh_l[TIME_BITS-1:0];
                r_rem_r <= w_ge_r ? TIME_BITS'(w_rsh_r - {1'b0, r_time}) : w_rsh_r[TIME_BITS-1:0];
                r_quo_l <= {r_quo_l[CHARGE_W-2:0], w_ge_l};
                r_quo_r <= {r_quo_r[CHARGE_W-2:0], w_ge_r};
            end
            ST_MUL_L, ST_MUL_R: begin
                r_prod <= PROD_W'(r_time) * PROD_W'(w_recip);
            end
            default: begin
                r_prod <= r_prod;
            end
        endcase
        if (w_out_load) begin
            r_out_checked <= r_checked;
            r_out_data    <= {w_trip_l | w_trip_r, w_trip_r, w_trip_l, r_avg_r, r_avg_l};
        end
    end

    assign o_s_axis_tready = w_s_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = 16'(r_out_data);
    assign o_m_axis_tuser  = r_out_checked;

endmodule
